FILE: src/sorted_table_engine_macros.svh
// ---------------------------------------------------------------------------
// sorted table engine assertion macros
// shared property forms for the concurrent checks of the engine
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_ENGINE_MACROS_SVH
`define SORTED_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define STE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted table engine check failed");

// next-cycle implication, checked outside reset
`define STE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted table engine check failed");

`endif

FILE: src/ste_pkg.sv
// ---------------------------------------------------------------------------
// ste_pkg
// types and constants shared by the sorted table engine modules
// ---------------------------------------------------------------------------
package ste_pkg;

  localparam int DATA_W = 32;
  localparam int FILL_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FWD    = 2'd2,
    OP_REV    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROT_L,
    CELL_ROT_R
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_TRAV
  } ctrl_state_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

FILE: src/ste_cell.sv
// ---------------------------------------------------------------------------
// ste_cell
// one slot of the sorted chain: holds a value and shifts with its neighbors
// ---------------------------------------------------------------------------
module ste_cell
  import ste_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] head_data,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic                     prev_valid,
  input  logic                     prev_gt,
  input  logic signed [DATA_W-1:0] next_data,
  input  logic                     next_valid,
  output logic signed [DATA_W-1:0] data,
  output logic                     valid,
  output logic                     gt,
  output logic                     eq
);

  logic signed [DATA_W-1:0] data_next;
  logic                     valid_next;
  logic                     ge;

  // empty slots count as larger than anything
  assign gt = !valid || (cmd.value < data);
  assign ge = valid && !(data < cmd.value);
  assign eq = valid && (data == cmd.value);

  always_comb begin
    data_next  = data;
    valid_next = valid;
    case (cmd.op)
      CELL_INSERT: begin
        if (gt) begin
          data_next = prev_gt ? prev_data : cmd.value;
        end
        valid_next = valid || prev_valid;
      end
      CELL_DELETE: begin
        if (ge) begin
          data_next  = next_data;
          valid_next = next_valid;
        end
      end
      CELL_ROT_L: begin
        if (valid) begin
          data_next = next_valid ? next_data : head_data;
        end
      end
      CELL_ROT_R: begin
        if (valid) begin
          data_next = prev_data;
        end
      end
      default: begin
        data_next  = data;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

FILE: src/ste_ctrl.sv
// ---------------------------------------------------------------------------
// ste_ctrl
// operation sequencer, entry count and registered result stage
// ---------------------------------------------------------------------------
module ste_ctrl
  import ste_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  op_t                      in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     res_valid,
  input  logic                     res_ready,
  output status_t                  res_status,
  output logic signed [DATA_W-1:0] res_value,
  output logic                     res_last,
  output logic [FILL_W-1:0]        res_fill,
  input  logic                     found,
  input  logic signed [DATA_W-1:0] head_data,
  input  logic signed [DATA_W-1:0] tail_data,
  output cell_cmd_t                cmd,
  output logic [CNT_W-1:0]         count
);

  ctrl_state_t              state, state_next;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         remain, remain_next;
  logic                     rev, rev_next;
  logic                     out_free;
  logic                     in_acc;
  logic                     full;
  logic                     load;
  status_t                  ld_status;
  logic signed [DATA_W-1:0] ld_value;
  logic                     ld_last;

  assign out_free = !res_valid || res_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_FWD || in_op == OP_REV) && count != '0) begin
          state_next = ST_TRAV;
        end
      end
      ST_TRAV: begin
        if (out_free && remain == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = CELL_HOLD;
    cmd.value   = in_value;
    count_next  = count;
    remain_next = remain;
    rev_next    = rev;
    load        = 1'b0;
    ld_status   = STAT_OK;
    ld_value    = in_value;
    ld_last     = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_INSERT: begin
              load = 1'b1;
              if (full) begin
                ld_status = STAT_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              load = 1'b1;
              if (count == '0) begin
                ld_status = STAT_EMPTY;
              end else if (!found) begin
                ld_status = STAT_NOTFOUND;
              end else begin
                cmd.op     = CELL_DELETE;
                count_next = count - CNT_W'(1);
              end
            end
            default: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = STAT_EMPTY;
                ld_value  = '0;
              end else begin
                remain_next = count;
                rev_next    = (in_op == OP_REV);
              end
            end
          endcase
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          load        = 1'b1;
          ld_value    = rev ? tail_data : head_data;
          ld_last     = (remain == CNT_W'(1));
          cmd.op      = rev ? CELL_ROT_R : CELL_ROT_L;
          remain_next = remain - CNT_W'(1);
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remain    <= '0;
      rev       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      rev    <= rev_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_status <= ld_status;
      res_value  <= ld_value;
      res_last   <= ld_last;
      res_fill   <= FILL_W'(count_next);
    end
  end

endmodule

FILE: src/sorted_table_engine.sv
// insert and delete: result registered in the cycle after the transaction, one per cycle while m_tready holds
// traversal of n entries: n results, one per cycle while m_tready holds; the first is loaded in ST_TRAV
// during a traversal the chain rotates one position per result
// reset clears the slot valid bits and the entry count; slot data is not reset
// ---------------------------------------------------------------------------
// sorted_table_engine
// bounded ascending table of signed values built as a chain of shifting slots
// ---------------------------------------------------------------------------
`include "sorted_table_engine_macros.svh"

module sorted_table_engine
  import ste_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic [1:0]  s_tuser,  // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] out_value, [37:32] fill, [39:38] zero
  output logic [1:0]  m_tuser,  // [1:0] status
  output logic        m_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] data_arr [CAPACITY];
  logic [CAPACITY-1:0]      valid_vec;
  logic [CAPACITY-1:0]      gt_vec;
  logic [CAPACITY-1:0]      eq_vec;
  logic [CAPACITY-1:0]      tail_sel;
  logic signed [DATA_W-1:0] head_data;
  logic signed [DATA_W-1:0] tail_data;
  logic                     found;
  logic [CNT_W-1:0]         count;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_value;
  logic [FILL_W-1:0]        res_fill;
  logic [CAPACITY:0]        valid_inc;

  assign head_data = data_arr[0];
  assign found     = |eq_vec;
  assign tail_sel  = valid_vec & ~{1'b0, valid_vec[CAPACITY-1:1]};

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_data = tail_data | (data_arr[i] & {DATA_W{tail_sel[i]}});
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] p_data;
    logic                     p_valid;
    logic                     p_gt;
    logic signed [DATA_W-1:0] n_data;
    logic                     n_valid;

    if (i == 0) begin : g_first
      assign p_data  = tail_data;
      assign p_valid = 1'b1;
      assign p_gt    = 1'b0;
    end else begin : g_mid
      assign p_data  = data_arr[i-1];
      assign p_valid = valid_vec[i-1];
      assign p_gt    = gt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_data  = head_data;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_data  = data_arr[i+1];
      assign n_valid = valid_vec[i+1];
    end

    ste_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .head_data  (head_data),
      .prev_data  (p_data),
      .prev_valid (p_valid),
      .prev_gt    (p_gt),
      .next_data  (n_data),
      .next_valid (n_valid),
      .data       (data_arr[i]),
      .valid      (valid_vec[i]),
      .gt         (gt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  ste_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (op_t'(s_tuser)),
    .in_value   (s_tdata),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_status (res_status),
    .res_value  (res_value),
    .res_last   (m_tlast),
    .res_fill   (res_fill),
    .found      (found),
    .head_data  (head_data),
    .tail_data  (tail_data),
    .cmd        (cmd),
    .count      (count)
  );

  assign m_tuser = res_status;
  assign m_tdata = {2'b00, res_fill, res_value};

  // occupied slots always form a prefix of the chain
  assign valid_inc = {1'b0, valid_vec} + (CAPACITY + 1)'(1);

  `STE_ASSERT_IMP(a_prefix, clk, rst, 1'b1, $onehot(valid_inc))
  `STE_ASSERT_IMP(a_count, clk, rst, 1'b1, $countones(valid_vec) == int'(count))
  `STE_ASSERT_IMP(a_one_item, clk, rst, m_tvalid && !m_tready, !s_tready)
  `STE_ASSERT_NXT(a_ins_grow, clk, rst,
    s_tvalid && s_tready && s_tuser == OP_INSERT && count != CNT_W'(CAPACITY),
    count == $past(count) + CNT_W'(1))

endmodule
